>>> design/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg: shared types and constants of the response frame parser
// Frame layout constants, phase and kind codes, the result word and the
// entry that travels from the parsing front to the output back.
// ----------------------------------------------------------------------------
package rfp_pkg;

	// frame layout
	localparam int HASH_BYTES      = 32;
	localparam int SIGNATURE_BYTES = 65;
	localparam int TCNT_W          = $clog2(SIGNATURE_BYTES + 2);

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// parse phases of the front
	typedef enum logic [2:0] {
		PH_HASH    = 3'd0,
		PH_COUNT   = 3'd1,
		PH_HEAD    = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_TRAIL   = 3'd4,
		PH_TAIL    = 3'd5
	} phase_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_HASH      = 3'd0,
		KIND_HEADER    = 3'd1,
		KIND_PAYLOAD   = 3'd2,
		KIND_TRAILER   = 3'd3,
		KIND_SIGNATURE = 3'd4,
		KIND_STATUS    = 3'd5
	} kind_t;

	// frame status codes
	typedef enum logic [1:0] {
		FS_COMPLETE  = 2'd0,
		FS_SIGNED    = 2'd1,
		FS_TRUNCATED = 2'd2
	} fstat_t;

	// one result word
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  record_number;
		logic [15:0] byte_offset;
		logic [7:0]  byte_value;
		logic [15:0] protocol_id;
		logic [15:0] payload_length;
		logic [15:0] time_to_live;
		logic [63:0] time_stamp;
		logic [7:0]  records_in_frame;
		fstat_t      frame_status;
		logic        last_of_run;
	} result_t;

	// what one accepted byte leaves for the back: a main word and/or a status
	typedef struct packed {
		logic       has_main;
		result_t    main;
		logic       has_status;
		logic [7:0] st_record;
		logic [7:0] st_count;
		fstat_t     st_status;
	} entry_t;

endpackage

>>> design/rfp_front.sv
// ----------------------------------------------------------------------------
// rfp_front: byte parser
// Takes one byte per cycle while not full, walks the frame layout and
// builds one queue entry for every byte that yields a word or ends the frame.
// ----------------------------------------------------------------------------
module rfp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [7:0]     data_byte,
	input  logic           end_of_frame,
	input  logic           q_full,
	output logic           full,
	output logic           ent_valid,
	output rfp_pkg::entry_t ent
);

	rfp_pkg::phase_t phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  nrec_q, nrec_d;
	logic [7:0]  rec_q, rec_d;
	logic [63:0] shift_q, shift_d;
	logic [15:0] proto_q, proto_d;
	logic [15:0] len_q, len_d;
	logic [15:0] ttl_q, ttl_d;
	logic [rfp_pkg::TCNT_W-1:0] tcnt_q, tcnt_d;
	logic        accept;
	logic [63:0] shifted;

	assign full    = q_full;
	assign accept  = push && !q_full;
	assign shifted = {shift_q[55:0], data_byte};

	// next state of the parser
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		nrec_d  = nrec_q;
		rec_d   = rec_q;
		shift_d = shift_q;
		proto_d = proto_q;
		len_d   = len_q;
		ttl_d   = ttl_q;
		tcnt_d  = tcnt_q;
		unique case (phase_q)
			rfp_pkg::PH_HASH: begin
				if (cnt_q == 16'(rfp_pkg::HASH_BYTES - 1)) begin
					cnt_d   = '0;
					phase_d = rfp_pkg::PH_COUNT;
				end else begin
					cnt_d = cnt_q + 16'd1;
				end
			end
			rfp_pkg::PH_COUNT: begin
				nrec_d  = data_byte;
				rec_d   = '0;
				cnt_d   = '0;
				phase_d = (data_byte != 8'd0) ? rfp_pkg::PH_HEAD : rfp_pkg::PH_TAIL;
			end
			rfp_pkg::PH_HEAD: begin
				if (cnt_q == 16'd3) begin
					proto_d = shifted[31:16];
					len_d   = shifted[15:0];
					shift_d = '0;
					cnt_d   = '0;
					phase_d = (shifted[15:0] != 16'd0) ? rfp_pkg::PH_PAYLOAD
						: rfp_pkg::PH_TRAIL;
				end else begin
					shift_d = shifted;
					cnt_d   = cnt_q + 16'd1;
				end
			end
			rfp_pkg::PH_PAYLOAD: begin
				if (cnt_q == len_q - 16'd1) begin
					cnt_d   = '0;
					phase_d = rfp_pkg::PH_TRAIL;
				end else begin
					cnt_d = cnt_q + 16'd1;
				end
			end
			rfp_pkg::PH_TRAIL: begin
				if (cnt_q == 16'd1) begin
					ttl_d   = shifted[15:0];
					shift_d = '0;
					cnt_d   = cnt_q + 16'd1;
				end else if (cnt_q == 16'd9) begin
					shift_d = '0;
					cnt_d   = '0;
					rec_d   = rec_q + 8'd1;
					phase_d = ((rec_q + 8'd1) >= nrec_q) ? rfp_pkg::PH_TAIL
						: rfp_pkg::PH_HEAD;
				end else begin
					shift_d = shifted;
					cnt_d   = cnt_q + 16'd1;
				end
			end
			rfp_pkg::PH_TAIL: begin
				if (tcnt_q < rfp_pkg::TCNT_W'(rfp_pkg::SIGNATURE_BYTES + 1)) begin
					tcnt_d = tcnt_q + rfp_pkg::TCNT_W'(1);
				end
			end
			default: begin
				phase_d = rfp_pkg::PH_HASH;
			end
		endcase
	end

	// entry for the back
	always_comb begin
		ent = '0;
		unique case (phase_q)
			rfp_pkg::PH_HASH: begin
				ent.has_main         = 1'b1;
				ent.main.kind        = rfp_pkg::KIND_HASH;
				ent.main.byte_offset = cnt_q;
				ent.main.byte_value  = data_byte;
			end
			rfp_pkg::PH_HEAD: begin
				if (cnt_q == 16'd3) begin
					ent.has_main            = 1'b1;
					ent.main.kind           = rfp_pkg::KIND_HEADER;
					ent.main.record_number  = rec_q;
					ent.main.protocol_id    = shifted[31:16];
					ent.main.payload_length = shifted[15:0];
				end
			end
			rfp_pkg::PH_PAYLOAD: begin
				ent.has_main            = 1'b1;
				ent.main.kind           = rfp_pkg::KIND_PAYLOAD;
				ent.main.record_number  = rec_q;
				ent.main.byte_offset    = cnt_q;
				ent.main.byte_value     = data_byte;
				ent.main.protocol_id    = proto_q;
				ent.main.payload_length = len_q;
			end
			rfp_pkg::PH_TRAIL: begin
				if (cnt_q == 16'd9) begin
					ent.has_main            = 1'b1;
					ent.main.kind           = rfp_pkg::KIND_TRAILER;
					ent.main.record_number  = rec_q;
					ent.main.protocol_id    = proto_q;
					ent.main.payload_length = len_q;
					ent.main.time_to_live   = ttl_q;
					ent.main.time_stamp     = shifted;
				end
			end
			rfp_pkg::PH_TAIL: begin
				if (tcnt_q < rfp_pkg::TCNT_W'(rfp_pkg::SIGNATURE_BYTES)) begin
					ent.has_main           = 1'b1;
					ent.main.kind          = rfp_pkg::KIND_SIGNATURE;
					ent.main.record_number = rec_q;
					ent.main.byte_offset   = 16'(tcnt_q);
					ent.main.byte_value    = data_byte;
				end
			end
			default: begin
				ent.has_main = 1'b0;
			end
		endcase
		// frame status on the final byte
		if (end_of_frame) begin
			ent.has_status = 1'b1;
			ent.st_record  = rec_d;
			ent.st_count   = nrec_d;
			if (phase_d != rfp_pkg::PH_TAIL) begin
				ent.st_status = rfp_pkg::FS_TRUNCATED;
			end else if (tcnt_d > rfp_pkg::TCNT_W'(rfp_pkg::SIGNATURE_BYTES)) begin
				ent.st_status = rfp_pkg::FS_SIGNED;
			end else begin
				ent.st_status = rfp_pkg::FS_COMPLETE;
			end
		end
		ent_valid = accept && (ent.has_main || ent.has_status);
	end

	// parser state, cleared at the end of every frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rfp_pkg::PH_HASH;
			cnt_q   <= '0;
			nrec_q  <= '0;
			rec_q   <= '0;
			shift_q <= '0;
			proto_q <= '0;
			len_q   <= '0;
			ttl_q   <= '0;
			tcnt_q  <= '0;
		end else if (accept) begin
			if (end_of_frame) begin
				phase_q <= rfp_pkg::PH_HASH;
				cnt_q   <= '0;
				nrec_q  <= '0;
				rec_q   <= '0;
				shift_q <= '0;
				proto_q <= '0;
				len_q   <= '0;
				ttl_q   <= '0;
				tcnt_q  <= '0;
			end else begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				nrec_q  <= nrec_d;
				rec_q   <= rec_d;
				shift_q <= shift_d;
				proto_q <= proto_d;
				len_q   <= len_d;
				ttl_q   <= ttl_d;
				tcnt_q  <= tcnt_d;
			end
		end
	end

endmodule

>>> design/rfp_queue.sv
// ----------------------------------------------------------------------------
// rfp_queue: entry queue between parser and output stage
// Small first-in first-out buffer of parser entries; write and read may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module rfp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  rfp_pkg::entry_t wr_data,
	output logic            q_full,
	input  logic            rd_en,
	output logic            rd_valid,
	output rfp_pkg::entry_t rd_data
);

	rfp_pkg::entry_t slot_q [rfp_pkg::QUEUE_DEPTH];
	logic [rfp_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [rfp_pkg::QCNT_W-1:0] count_q;
	logic do_wr, do_rd;

	assign q_full   = (count_q == rfp_pkg::QCNT_W'(rfp_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rptr_q];
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + rfp_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + rfp_pkg::QPTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + rfp_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - rfp_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/rfp_back.sv
// ----------------------------------------------------------------------------
// rfp_back: output stage
// Unpacks queue entries into result words, main word first and status second,
// and holds the oldest word in an output register until it is popped.
// ----------------------------------------------------------------------------
module rfp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  rfp_pkg::entry_t  q_data,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output rfp_pkg::result_t word
);

	logic             out_valid_q;
	rfp_pkg::result_t out_q;
	logic             status_next_q;
	logic             load;
	logic             take_main;
	rfp_pkg::result_t next_word;

	assign load      = !out_valid_q || pop;
	assign take_main = q_data.has_main && !status_next_q;
	assign q_pop     = load && q_valid && (!take_main || !q_data.has_status);
	assign empty     = !out_valid_q;
	assign word      = out_q;

	// select the next word from the head entry
	always_comb begin
		next_word = '0;
		if (take_main) begin
			next_word             = q_data.main;
			next_word.last_of_run = !q_data.has_status;
		end else begin
			next_word.kind             = rfp_pkg::KIND_STATUS;
			next_word.record_number    = q_data.st_record;
			next_word.records_in_frame = q_data.st_count;
			next_word.frame_status     = q_data.st_status;
			next_word.last_of_run      = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			status_next_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_valid;
			if (q_valid) begin
				status_next_q <= take_main && q_data.has_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			out_q <= next_word;
		end
	end

endmodule

>>> design/response_frame_parser.sv
// ----------------------------------------------------------------------------
// response_frame_parser: response frame byte parser
// Top level: parser front, entry queue and output stage.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle and returns hash, record header, payload,
// record trailer, signature and frame status words in frame order. A byte is
// taken every cycle while full is low. full rises when the four-entry queue
// between parser and output stage fills. That happens when words are not
// popped, or when a run of final bytes each yields two words. Each byte yields
// at most one word, except the final byte, which adds the status word. The
// output stage delivers one word per cycle while words are popped. A word
// passes through the entry queue and then the output register before it
// reaches the result ports. Consumers drop all words of a frame whose
// status is truncated.
// ----------------------------------------------------------------------------
module response_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               end_of_frame,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         kind,
	output logic [7:0]         record_number,
	output logic [15:0]        byte_offset,
	output logic [7:0]         byte_value,
	output logic [15:0]        protocol_id,
	output logic [15:0]        payload_length,
	output logic [15:0]        time_to_live,
	output logic signed [63:0] time_stamp,
	output logic [7:0]         records_in_frame,
	output logic [1:0]         frame_status,
	output logic               last_of_run
);

	logic             q_full;
	logic             ent_valid;
	rfp_pkg::entry_t  ent;
	logic             q_valid;
	logic             q_pop;
	rfp_pkg::entry_t  q_data;
	rfp_pkg::result_t word;

	rfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.data_byte    (data_byte),
		.end_of_frame (end_of_frame),
		.q_full       (q_full),
		.full         (full),
		.ent_valid    (ent_valid),
		.ent          (ent)
	);

	rfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (ent_valid),
		.wr_data  (ent),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	rfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.word    (word)
	);

	// result ports
	assign kind             = word.kind;
	assign record_number    = word.record_number;
	assign byte_offset      = word.byte_offset;
	assign byte_value       = word.byte_value;
	assign protocol_id      = word.protocol_id;
	assign payload_length   = word.payload_length;
	assign time_to_live     = word.time_to_live;
	assign time_stamp       = word.time_stamp;
	assign records_in_frame = word.records_in_frame;
	assign frame_status     = word.frame_status;
	assign last_of_run      = word.last_of_run;

endmodule

>>> design/rfp_checker.sv
// ----------------------------------------------------------------------------
// rfp_checker: port-level checks of the response frame parser
// Watches the result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module rfp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [2:0]         kind,
	input logic [15:0]        byte_offset,
	input logic [15:0]        time_to_live,
	input logic signed [63:0] time_stamp,
	input logic [7:0]         records_in_frame,
	input logic [1:0]         frame_status,
	input logic               last_of_run
);

	// a status word always closes the run of its byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == rfp_pkg::KIND_STATUS) |-> last_of_run)
		else $error("status word without last_of_run");

	// only status words carry a frame status or a record count
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != rfp_pkg::KIND_STATUS)
			|-> (frame_status == 2'd0 && records_in_frame == 8'd0))
		else $error("status fields set on a non-status word");

	// ttl and timestamp travel with the record trailer only
	a_trailer_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != rfp_pkg::KIND_TRAILER)
			|-> (time_to_live == 16'd0 && time_stamp == 64'sd0))
		else $error("trailer fields set on another word");

	// the kind, offset and last_of_run of a waiting word hold until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(byte_offset)
			&& $stable(last_of_run)))
		else $error("waiting word changed before pop");

endmodule

bind response_frame_parser rfp_checker u_rfp_checker (.*);
